>>> design/stit_pkg.sv
// Shared types, widths and constants for the sorted timestamp index table.
package stit_pkg;

	// Table depth default
	localparam int DEPTH_DEF = 256;

	// Field widths
	localparam int CMD_W     = 2;
	localparam int MIN_W     = 7;
	localparam int SEC_W     = 7;
	localparam int FVAL_W    = 10;
	localparam int FDIG_W    = 2;
	localparam int POS_W     = 32;
	localparam int IDX_W     = 13;
	localparam int TIME_W    = 23;
	localparam int CNT_W     = 13;
	localparam int STAT_W    = 2;
	localparam int TOTSEC_W  = 13;
	localparam int FRAC_W    = 17;

	// Stream widths
	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 56;
	localparam int M_TUSER_W = 2;

	// Conversion constants
	localparam int SEC_PER_MIN = 60;
	localparam int MS_PER_SEC  = 1000;
	localparam int SCALE_ONE   = 100;
	localparam int SCALE_TWO   = 10;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic conv1;
		logic conv2;
		logic srch_init;
		logic srch_issue;
		logic srch_cmp;
		logic sh_init;
		logic sh_step;
		logic wr_new;
		logic rd_issue;
		logic finish;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic srch_done;
		logic sh_done;
		logic rd_ok;
	} dp_stat_t;

endpackage

>>> design/stit_ctrl.sv
// Controller state machine sequencing clear, insert, search and read transactions.
module stit_ctrl
	import stit_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  cmd_t     in_cmd,
	output logic     out_valid,
	input  logic     out_ready,
	output dp_cmd_t  dp_cmd,
	input  dp_stat_t dp_stat
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CONV1,
		ST_CONV2,
		ST_SINIT,
		ST_SISSUE,
		ST_SCMP,
		ST_SHINIT,
		ST_SHIFT,
		ST_RISSUE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Command decode
	always_comb begin
		dp_cmd = '0;
		unique case (state_q)
			ST_IDLE:   dp_cmd.load       = in_valid;
			ST_CONV1:  dp_cmd.conv1      = 1'b1;
			ST_CONV2:  dp_cmd.conv2      = 1'b1;
			ST_SINIT:  dp_cmd.srch_init  = 1'b1;
			ST_SISSUE: dp_cmd.srch_issue = !dp_stat.srch_done;
			ST_SCMP:   dp_cmd.srch_cmp   = 1'b1;
			ST_SHINIT: dp_cmd.sh_init    = 1'b1;
			ST_SHIFT: begin
				dp_cmd.sh_step = !dp_stat.sh_done;
				dp_cmd.wr_new  = dp_stat.sh_done;
			end
			ST_RISSUE: dp_cmd.rd_issue   = dp_stat.rd_ok;
			ST_FINISH: dp_cmd.finish     = out_free;
			default:   dp_cmd = '0;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (dp_cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						unique case (in_cmd)
							CMD_CLEAR:  state_q <= ST_FINISH;
							CMD_INSERT: state_q <= ST_CONV1;
							CMD_SEARCH: state_q <= ST_SINIT;
							CMD_READ:   state_q <= ST_RISSUE;
							default:    state_q <= ST_FINISH;
						endcase
					end
				end
				ST_CONV1:  state_q <= ST_CONV2;
				ST_CONV2:  state_q <= dp_stat.full ? ST_FINISH : ST_SINIT;
				ST_SINIT:  state_q <= ST_SISSUE;
				ST_SISSUE: begin
					if (!dp_stat.srch_done) begin
						state_q <= ST_SCMP;
					end else if (dp_stat.cmd == CMD_INSERT) begin
						state_q <= ST_SHINIT;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_SCMP:   state_q <= ST_SISSUE;
				ST_SHINIT: state_q <= ST_SHIFT;
				ST_SHIFT: begin
					if (dp_stat.sh_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_RISSUE: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// A held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result loaded while previous result still held");

	// Output valid only rises after a finished transaction
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(dp_cmd.finish))
		else $error("output valid rose without a finish");

	// A full table never enters the shift phase
	a_full_no_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHINIT) |-> !dp_stat.full)
		else $error("shift started on a full table");

endmodule

>>> design/stit_dp.sv
// Datapath: time conversion, table memory, binary search, insert shift and result register.
module stit_dp
	import stit_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             dp_cmd,
	output dp_stat_t            dp_stat,
	input  cmd_t                in_cmd,
	input  logic [MIN_W-1:0]    in_minutes,
	input  logic [SEC_W-1:0]    in_seconds,
	input  logic [FVAL_W-1:0]   in_frac_value,
	input  logic [FDIG_W-1:0]   in_frac_digits,
	input  logic [POS_W-1:0]    in_position_ms,
	input  logic [IDX_W-1:0]    in_query_index,
	output logic [IDX_W-1:0]    out_found_index,
	output logic [TIME_W-1:0]   out_time_ms,
	output logic [CNT_W-1:0]    out_line_count,
	output status_t             out_status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// Accepted transaction fields
	cmd_t                cmd_q;
	logic [MIN_W-1:0]    min_q;
	logic [SEC_W-1:0]    sec_q;
	logic [FVAL_W-1:0]   fval_q;
	logic [FDIG_W-1:0]   fdig_q;
	logic [POS_W-1:0]    pos_q;
	logic [IDX_W-1:0]    qidx_q;

	// Conversion
	logic [TOTSEC_W-1:0] totsec_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [TIME_W-1:0]   time_q;

	// Search and shift
	logic [POS_W-1:0]    key_q;
	logic [CW-1:0]       lo_q;
	logic [CW-1:0]       hi_q;
	logic [AW-1:0]       mid_q;
	logic [TIME_W-1:0]   hit_time_q;
	logic [AW-1:0]       k_q;
	logic [AW-1:0]       wk_q;
	logic                pend_q;
	logic [CW-1:0]       count_q;

	// Memory
	logic [TIME_W-1:0]   mem [DEPTH];
	logic [TIME_W-1:0]   rd_data_q;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [TIME_W-1:0]   wr_data;

	logic [CW:0]         mid_sum;
	logic [AW-1:0]       mid;
	logic                k_above;
	logic                full;
	logic                rd_ok;
	logic [FRAC_W-1:0]   frac_scaled;

	assign mid_sum = (CW+1)'(lo_q) + (CW+1)'(hi_q);
	assign mid     = mid_sum[AW:1];
	assign k_above = CW'(k_q) > lo_q;
	assign full    = (count_q == CW'(DEPTH));
	assign rd_ok   = !qidx_q[IDX_W-1] && (qidx_q < IDX_W'(count_q));

	assign dp_stat.cmd       = cmd_q;
	assign dp_stat.full      = full;
	assign dp_stat.srch_done = (lo_q >= hi_q);
	assign dp_stat.sh_done   = (CW'(k_q) == lo_q) && !pend_q;
	assign dp_stat.rd_ok     = rd_ok;

	// Fraction scaling by digit count
	always_comb begin
		unique case (fdig_q)
			2'd1:    frac_scaled = FRAC_W'(fval_q) * FRAC_W'(SCALE_ONE);
			2'd2:    frac_scaled = FRAC_W'(fval_q) * FRAC_W'(SCALE_TWO);
			2'd3:    frac_scaled = FRAC_W'(fval_q);
			default: frac_scaled = '0;
		endcase
	end

	// Memory port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mid;
		if (dp_cmd.srch_issue) begin
			rd_en   = 1'b1;
			rd_addr = mid;
		end else if (dp_cmd.sh_step && k_above) begin
			rd_en   = 1'b1;
			rd_addr = k_q - AW'(1);
		end else if (dp_cmd.rd_issue) begin
			rd_en   = 1'b1;
			rd_addr = qidx_q[AW-1:0];
		end
		wr_en   = (dp_cmd.sh_step && pend_q) || dp_cmd.wr_new;
		wr_addr = dp_cmd.wr_new ? lo_q[AW-1:0] : wk_q;
		wr_data = dp_cmd.wr_new ? time_q : rd_data_q;
	end

	// Table memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q  <= in_cmd;
			min_q  <= in_minutes;
			sec_q  <= in_seconds;
			fval_q <= in_frac_value;
			fdig_q <= in_frac_digits;
			pos_q  <= in_position_ms;
			qidx_q <= in_query_index;
		end
		if (dp_cmd.conv1) begin
			totsec_q <= TOTSEC_W'(min_q) * TOTSEC_W'(SEC_PER_MIN) + TOTSEC_W'(sec_q);
			frac_q   <= frac_scaled;
		end
		if (dp_cmd.conv2) begin
			time_q <= TIME_W'(totsec_q) * TIME_W'(MS_PER_SEC) + TIME_W'(frac_q);
		end
		if (dp_cmd.srch_init) begin
			key_q <= (cmd_q == CMD_SEARCH) ? pos_q : POS_W'(time_q);
		end
		if (dp_cmd.srch_issue) begin
			mid_q <= mid;
		end
		if (dp_cmd.srch_cmp && (POS_W'(rd_data_q) <= key_q)) begin
			hit_time_q <= rd_data_q;
		end
		if (dp_cmd.sh_step && k_above) begin
			wk_q <= k_q;
		end
		if (dp_cmd.finish) begin
			unique case (cmd_q)
				CMD_CLEAR: begin
					out_found_index <= '1;
					out_time_ms     <= '0;
					out_line_count  <= '0;
					out_status      <= STAT_OK;
				end
				CMD_INSERT: begin
					out_time_ms <= time_q;
					if (full) begin
						out_found_index <= '1;
						out_line_count  <= CNT_W'(count_q);
						out_status      <= STAT_FULL;
					end else begin
						out_found_index <= IDX_W'(lo_q);
						out_line_count  <= CNT_W'(count_q) + CNT_W'(1);
						out_status      <= STAT_OK;
					end
				end
				CMD_SEARCH: begin
					out_line_count <= CNT_W'(count_q);
					out_status     <= STAT_OK;
					if (lo_q == '0) begin
						out_found_index <= '1;
						out_time_ms     <= '0;
					end else begin
						out_found_index <= IDX_W'(lo_q) - IDX_W'(1);
						out_time_ms     <= hit_time_q;
					end
				end
				CMD_READ: begin
					out_line_count <= CNT_W'(count_q);
					if (rd_ok) begin
						out_found_index <= qidx_q;
						out_time_ms     <= rd_data_q;
						out_status      <= STAT_OK;
					end else begin
						out_found_index <= '1;
						out_time_ms     <= '0;
						out_status      <= STAT_RANGE;
					end
				end
				default: begin
					out_found_index <= '1;
					out_time_ms     <= '0;
					out_line_count  <= CNT_W'(count_q);
					out_status      <= STAT_OK;
				end
			endcase
		end
	end

	// Control registers: search bounds, shift pointer, entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q    <= '0;
			hi_q    <= '0;
			k_q     <= '0;
			pend_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (dp_cmd.srch_init) begin
				lo_q <= '0;
				hi_q <= count_q;
			end else if (dp_cmd.srch_cmp) begin
				if (POS_W'(rd_data_q) <= key_q) begin
					lo_q <= CW'(mid_q) + CW'(1);
				end else begin
					hi_q <= CW'(mid_q);
				end
			end
			if (dp_cmd.sh_init) begin
				k_q    <= count_q[AW-1:0];
				pend_q <= 1'b0;
			end else if (dp_cmd.sh_step) begin
				if (k_above) begin
					k_q    <= k_q - AW'(1);
					pend_q <= 1'b1;
				end else begin
					pend_q <= 1'b0;
				end
			end
			if (dp_cmd.finish) begin
				if (cmd_q == CMD_CLEAR) begin
					count_q <= '0;
				end else if ((cmd_q == CMD_INSERT) && !full) begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	// Entry count stays within the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	// A probe is only issued on a non-empty search window
	a_probe_window: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.srch_issue |=> (CW'(mid_q) >= lo_q) && (CW'(mid_q) < hi_q))
		else $error("search probe outside window");

	// Shift pointer never passes the insert slot
	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.sh_step |-> (CW'(k_q) >= lo_q))
		else $error("shift pointer below insert slot");

	// A new entry is only written when there is room
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.wr_new |-> !full)
		else $error("entry written into a full table");

endmodule

>>> design/sorted_timestamp_index_table_top.sv
// Top level of the sorted timestamp index table: stream ports, controller and datapath.
// Clear and read do no search; search runs a binary search, each probe a read on the table
// memory's read port followed by a compare.
// Insert converts the time, searches for its slot, then does a one-entry-per-cycle shift
// through the table memory's read and write ports; an insert on a full table skips both.
// One transaction is worked at a time; the next is accepted while a result waits on the output.
// Asynchronous active-low reset empties the table; stored times are not cleared.
module sorted_timestamp_index_table_top
	import stit_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// minutes[6:0], seconds[13:7], frac_value[23:14], frac_digits[25:24],
	// position_ms[57:26], query_index[70:58], zero pad[71]
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// cmd[1:0]
	input  logic [S_TUSER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// found_index[12:0], time_ms[35:13], line_count[48:36], zero pad[55:49]
	output logic [M_TDATA_W-1:0]  m_tdata,
	// status[1:0]
	output logic [M_TUSER_W-1:0]  m_tuser
);

	localparam int PAD_W = M_TDATA_W - IDX_W - TIME_W - CNT_W;

	dp_cmd_t             dp_cmd;
	dp_stat_t            dp_stat;
	cmd_t                in_cmd;
	logic [IDX_W-1:0]    found_index;
	logic [TIME_W-1:0]   time_ms;
	logic [CNT_W-1:0]    line_count;
	status_t             status;

	assign in_cmd = cmd_t'(s_tuser[CMD_W-1:0]);

	stit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (in_cmd),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat)
	);

	stit_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.dp_cmd          (dp_cmd),
		.dp_stat         (dp_stat),
		.in_cmd          (in_cmd),
		.in_minutes      (s_tdata[6:0]),
		.in_seconds      (s_tdata[13:7]),
		.in_frac_value   (s_tdata[23:14]),
		.in_frac_digits  (s_tdata[25:24]),
		.in_position_ms  (s_tdata[57:26]),
		.in_query_index  (s_tdata[70:58]),
		.out_found_index (found_index),
		.out_time_ms     (time_ms),
		.out_line_count  (line_count),
		.out_status      (status)
	);

	// Result packing
	assign m_tdata = {{PAD_W{1'b0}}, line_count, time_ms, found_index};
	assign m_tuser = M_TUSER_W'(status);

endmodule

>>> test/sorted_timestamp_index_table_top_tb.sv
// Self-checking testbench for the sorted timestamp index table top level.
module sorted_timestamp_index_table_top_tb
	import stit_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int DIR_N        = 25;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 400;
	localparam int CYCLE_LIMIT  = 4000000;

	// One command as it travels on the input stream
	typedef struct packed {
		cmd_t                    cmd;
		logic [MIN_W-1:0]        mins;
		logic [SEC_W-1:0]        secs;
		logic [FVAL_W-1:0]       fval;
		logic [FDIG_W-1:0]       fdig;
		logic [POS_W-1:0]        pos;
		logic signed [IDX_W-1:0] qidx;
	} ts_req_t;

	// One reply as it travels on the output stream
	typedef struct packed {
		logic signed [IDX_W-1:0] idx;
		logic [TIME_W-1:0]       tms;
		logic [CNT_W-1:0]        cnt;
		status_t                 stat;
	} ts_reply_t;

	typedef struct packed {
		logic      typed;
		ts_req_t   req;
		ts_reply_t reply;
	} ts_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	// Mirror of the table and the replies still owed by the block
	logic [TIME_W-1:0] ms_table [DEPTH];
	int                ms_count;
	ts_reply_t         awaited_replies [$];
	int                accepted_reqs;
	int                errors;
	int                idle_mode;
	bit                hold_req;
	logic              row_typed;
	ts_reply_t         row_reply;
	int                cycles;
	ts_row_t           directed [DIR_N];

	sorted_timestamp_index_table_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Minutes, seconds and fraction digits to milliseconds
	function automatic logic [TIME_W-1:0] to_ms(ts_req_t r);
		int frac;
		case (r.fdig)
			2'd1: frac = int'(r.fval) * SCALE_ONE;
			2'd2: frac = int'(r.fval) * SCALE_TWO;
			2'd3: frac = int'(r.fval);
			default: frac = 0;
		endcase
		return TIME_W'((int'(r.mins) * SEC_PER_MIN + int'(r.secs)) * MS_PER_SEC + frac);
	endfunction

	// Last stored index at or below pos, -1 if none
	function automatic int last_at_or_below(logic [POS_W-1:0] pos);
		int found;
		found = -1;
		for (int i = 0; i < ms_count; i++)
			if (POS_W'(ms_table[i]) <= pos)
				found = i;
		return found;
	endfunction

	// Apply one command to the mirror table and return the reply it owes
	function automatic ts_reply_t apply_table_cmd(ts_req_t r);
		ts_reply_t y;
		int slot;
		int q;
		y.idx  = '1;
		y.tms  = '0;
		y.stat = STAT_OK;
		case (r.cmd)
			CMD_CLEAR: ms_count = 0;
			CMD_INSERT: begin
				y.tms = to_ms(r);
				if (ms_count >= DEPTH) begin
					y.stat = STAT_FULL;
				end else begin
					slot = last_at_or_below(POS_W'(y.tms)) + 1;
					for (int k = ms_count; k > slot; k--)
						ms_table[k] = ms_table[k-1];
					ms_table[slot] = y.tms;
					ms_count++;
					y.idx = IDX_W'(slot);
				end
			end
			CMD_SEARCH: begin
				slot = last_at_or_below(r.pos);
				y.idx = IDX_W'(slot);
				if (slot >= 0)
					y.tms = ms_table[slot];
			end
			default: begin
				q = int'($signed(r.qidx));
				if (q < 0 || q >= ms_count) begin
					y.stat = STAT_RANGE;
				end else begin
					y.idx = IDX_W'(q);
					y.tms = ms_table[q];
				end
			end
		endcase
		y.cnt = CNT_W'(ms_count);
		return y;
	endfunction

	function automatic ts_row_t mk_row(logic ty, cmd_t c, int mn, int sc, int fv, int fd,
			logic [POS_W-1:0] pos, int q, int ei, int et, int ec, status_t es);
		ts_row_t w;
		w.typed      = ty;
		w.req.cmd    = c;
		w.req.mins   = MIN_W'(mn);
		w.req.secs   = SEC_W'(sc);
		w.req.fval   = FVAL_W'(fv);
		w.req.fdig   = FDIG_W'(fd);
		w.req.pos    = pos;
		w.req.qidx   = IDX_W'(q);
		w.reply.idx  = IDX_W'(ei);
		w.reply.tms  = TIME_W'(et);
		w.reply.cnt  = CNT_W'(ec);
		w.reply.stat = es;
		return w;
	endfunction

	// Random command; unused fields carry random junk
	function automatic ts_req_t random_req(int insert_pct, int clear_pct);
		ts_req_t r;
		int pick;
		int kind;
		r.mins = MIN_W'($urandom);
		r.secs = SEC_W'($urandom);
		r.fval = FVAL_W'($urandom);
		r.fdig = FDIG_W'($urandom);
		r.pos  = $urandom;
		r.qidx = IDX_W'($urandom);
		pick = $urandom_range(0, 99);
		kind = $urandom_range(0, 9);
		if (pick < clear_pct) begin
			r.cmd = CMD_CLEAR;
		end else if (pick < clear_pct + insert_pct) begin
			r.cmd = CMD_INSERT;
			// narrow values give many equal timestamps
			if (kind < 3) begin
				r.mins = MIN_W'($urandom_range(0, 1));
				r.secs = SEC_W'($urandom_range(0, 2));
				r.fval = FVAL_W'($urandom_range(0, 3));
			end
		end else if (pick < clear_pct + insert_pct + (100 - clear_pct - insert_pct) / 2) begin
			r.cmd = CMD_SEARCH;
			if (kind < 4 && ms_count > 0)
				r.pos = POS_W'(ms_table[$urandom_range(0, ms_count - 1)])
					+ POS_W'($urandom_range(0, 2)) - 1;
			else if (kind < 6)
				r.pos = POS_W'(TIME_W'($urandom));
			else if (kind == 8)
				r.pos = '0;
			else if (kind == 9)
				r.pos = '1;
		end else begin
			r.cmd = CMD_READ;
			if (kind < 6 && ms_count > 0)
				r.qidx = IDX_W'($urandom_range(0, ms_count - 1));
			else if (kind == 6)
				r.qidx = IDX_W'(ms_count);
			else if (kind == 7)
				r.qidx = '1;
		end
		return r;
	endfunction

	function automatic bit sender_idles();
		return (idle_mode == 1 && $urandom_range(0, 99) < 45) ||
			(idle_mode == 3 && $urandom_range(0, 99) < 9);
	endfunction

	function automatic bit receiver_stalls();
		return (idle_mode == 2 && $urandom_range(0, 99) < 45) ||
			(idle_mode == 3 && $urandom_range(0, 99) < 9);
	endfunction

	// Present one command and wait for its transaction; called at a falling edge
	task automatic offer(ts_req_t r, logic typed, ts_reply_t want);
		int seen;
		while (sender_idles()) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tdata   <= {1'b0, r.qidx, r.pos, r.fdig, r.fval, r.secs, r.mins};
		s_tuser   <= r.cmd;
		row_typed <= typed;
		row_reply <= want;
		seen = accepted_reqs;
		do @(negedge clk); while (accepted_reqs == seen);
	endtask

	// Stop offering until every owed reply has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (awaited_replies.size() != 0);
	endtask

	// Stimulus
	initial begin
		arst_n    = 1'b0;
		clk       = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		row_typed = 1'b0;
		row_reply = '0;
		idle_mode = 0;
		hold_req  = 1'b0;
		// typed rows carry their reply; the others are checked against the mirror table
		directed = '{
			mk_row(1'b1, CMD_READ,     0,   0,    0, 0, 32'd0,  0, -1,       0, 0, STAT_RANGE),
			mk_row(1'b1, CMD_SEARCH,   0,   0,    0, 0, 32'd0,  0, -1,       0, 0, STAT_OK),
			mk_row(1'b1, CMD_SEARCH,   0,   0,    0, 0,    '1,  0, -1,       0, 0, STAT_OK),
			mk_row(1'b1, CMD_INSERT,   0,   0,    0, 0, 32'd0,  0,  0,       0, 1, STAT_OK),
			mk_row(1'b1, CMD_INSERT, 127, 127, 1023, 1, 32'd0,  0,  1, 7849300, 2, STAT_OK),
			mk_row(1'b0, CMD_INSERT,   1,   2,    5, 1, 32'd0,  0,  0,       0, 0, STAT_OK),
			mk_row(1'b0, CMD_INSERT,   1,   2,   50, 2, 32'd0,  0,  0,       0, 0, STAT_OK),
			mk_row(1'b0, CMD_INSERT,   1,   2,  500, 3, 32'd0,  0,  0,       0, 0, STAT_OK),
			mk_row(1'b0, CMD_INSERT,   0,   0, 1023, 3, 32'd0,  0,  0,       0, 0, STAT_OK),
			mk_row(1'b0, CMD_INSERT,   0,   0, 1023, 2, 32'd0,  0,  0,       0, 0, STAT_OK),
			mk_row(1'b0, CMD_INSERT,   0,   0,    7, 0, 32'd0,  0,  0,       0, 0, STAT_OK),
			mk_row(1'b0, CMD_SEARCH,   0,   0,    0, 0, 32'd62500, 0, 0,     0, 0, STAT_OK),
			mk_row(1'b0, CMD_SEARCH,   0,   0,    0, 0, 32'd62499, 0, 0,     0, 0, STAT_OK),
			mk_row(1'b0, CMD_SEARCH,   0,   0,    0, 0,    '1,  0,  0,       0, 0, STAT_OK),
			mk_row(1'b0, CMD_SEARCH,   0,   0,    0, 0, 32'd0,  0,  0,       0, 0, STAT_OK),
			mk_row(1'b1, CMD_READ,     0,   0,    0, 0, 32'd0, -1, -1,       0, 8, STAT_RANGE),
			mk_row(1'b1, CMD_READ,     0,   0,    0, 0, 32'd0,  8, -1,       0, 8, STAT_RANGE),
			mk_row(1'b0, CMD_READ,     0,   0,    0, 0, 32'd0,  7,  0,       0, 0, STAT_OK),
			mk_row(1'b1, CMD_READ,     0,   0,    0, 0, 32'd0, -4096, -1,    0, 8, STAT_RANGE),
			mk_row(1'b1, CMD_READ,     0,   0,    0, 0, 32'd0, 4095, -1,     0, 8, STAT_RANGE),
			mk_row(1'b0, CMD_READ,     0,   0,    0, 0, 32'd0,  0,  0,       0, 0, STAT_OK),
			mk_row(1'b1, CMD_CLEAR,  127, 127, 1023, 3,    '1, -1, -1,       0, 0, STAT_OK),
			mk_row(1'b1, CMD_SEARCH,   0,   0,    0, 0, 32'd5,  0, -1,       0, 0, STAT_OK),
			mk_row(1'b1, CMD_READ,     0,   0,    0, 0, 32'd0,  0, -1,       0, 0, STAT_RANGE),
			mk_row(1'b1, CMD_INSERT,  99,  59,  999, 3, 32'd0,  0,  0, 5999999, 1, STAT_OK)
		};
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			offer(directed[i].req, directed[i].typed, directed[i].reply);
		settle();

		// Each idling phase: clear, fill past full, then a mixed stretch
		for (int mode = 0; mode < 4; mode++) begin
			idle_mode = mode;
			offer(random_req(0, 100), 1'b0, '0);
			repeat (320) offer(random_req(90, 0), 1'b0, '0);
			if (mode == 0) begin
				// output held off while commands keep coming
				hold_req = 1'b1;
				repeat (40) offer(random_req(20, 0), 1'b0, '0);
			end
			repeat (130) offer(random_req(40, 3), 1'b0, '0);
			settle();
		end

		idle_mode = 0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Output side ready, with one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= !receiver_stalls();
		end
	end

	// Check replies, then record accepted commands
	always @(posedge clk) begin
		ts_req_t   r;
		ts_reply_t got;
		ts_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.idx  = m_tdata[0 +: IDX_W];
			got.tms  = m_tdata[IDX_W +: TIME_W];
			got.cnt  = m_tdata[IDX_W + TIME_W +: CNT_W];
			got.stat = status_t'(m_tuser);
			if (awaited_replies.size() == 0) begin
				errors++;
				$display("%0t: reply with none owed: found_index %0d time_ms %0d",
					$time, $signed(got.idx), got.tms);
			end else begin
				want = awaited_replies.pop_front();
				if (got.idx !== want.idx) begin
					errors++;
					$display("%0t: found_index expected %0d got %0d",
						$time, $signed(want.idx), $signed(got.idx));
				end
				if (got.tms !== want.tms) begin
					errors++;
					$display("%0t: time_ms expected %0d got %0d", $time, want.tms, got.tms);
				end
				if (got.cnt !== want.cnt) begin
					errors++;
					$display("%0t: line_count expected %0d got %0d", $time, want.cnt, got.cnt);
				end
				if (got.stat !== want.stat) begin
					errors++;
					$display("%0t: status expected %0d got %0d", $time, want.stat, got.stat);
				end
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			r.cmd  = cmd_t'(s_tuser);
			r.mins = s_tdata[0 +: MIN_W];
			r.secs = s_tdata[7 +: SEC_W];
			r.fval = s_tdata[14 +: FVAL_W];
			r.fdig = s_tdata[24 +: FDIG_W];
			r.pos  = s_tdata[26 +: POS_W];
			r.qidx = s_tdata[58 +: IDX_W];
			want = apply_table_cmd(r);
			if (row_typed)
				want = row_reply;
			awaited_replies.push_back(want);
			accepted_reqs++;
		end
	end

	// Run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		ms_count      = 0;
		accepted_reqs = 0;
		errors        = 0;
	end

endmodule
